// ----- design/swms_pkg.sv -----
// Shared types and constants for the sliding window mean and deviation block.
package swms_pkg;

  localparam int unsigned WindowSizeDef = 128;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned FillW         = 8;
  localparam int unsigned SqW           = 32;
  localparam int unsigned InQueueDepth  = 2;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                       command;
    logic signed [SampleW-1:0]  sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } in_head_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_SUM_GO,
    ST_SUM_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MUL,
    ST_VAR,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DONE
  } back_state_e;

endpackage

// ----- design/sliding_window_mean_stddev.sv -----
// Top level: sliding window mean and standard deviation over Q8.8 samples.
// A push runs the serial divider twice, for the mean and the mean square, then the square root unit.
// A clear skips them and goes straight to the result register.
// Items are handled one at a time, two items queue at the input and one result waits at the output.
// Reset clears the window at once; the sample store needs no clearing pass.
module sliding_window_mean_stddev #(
  parameter int unsigned WINDOW_SIZE = swms_pkg::WindowSizeDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 command_i,
  input  logic signed [swms_pkg::SampleW-1:0]  sample_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [swms_pkg::SampleW-1:0]  mean_o,
  output logic [swms_pkg::SampleW-1:0]         std_dev_o,
  output logic [swms_pkg::FillW-1:0]           fill_count_o,
  output logic                                 full_res_o
);

  swms_pkg::item_t    in_item;
  swms_pkg::in_head_t head;
  logic               take;

  assign in_item.command = swms_pkg::cmd_e'(command_i);
  assign in_item.sample  = sample_i;

  swms_in_queue u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .item_i (in_item),
    .take_i (take),
    .head_o (head)
  );

  swms_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .take_o       (take),
    .empty        (empty),
    .pop          (pop),
    .mean_o       (mean_o),
    .std_dev_o    (std_dev_o),
    .fill_count_o (fill_count_o),
    .full_res_o   (full_res_o)
  );

endmodule

// ----- design/swms_in_queue.sv -----
// Input queue that takes command beats and holds them for the back end.
module swms_in_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  swms_pkg::item_t   item_i,
  input  logic              take_i,
  output swms_pkg::in_head_t head_o
);

  localparam int unsigned Depth = swms_pkg::InQueueDepth;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  swms_pkg::item_t slot_q [Depth];
  logic [IdxW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_take;

  assign full    = (cnt_q == CntW'(Depth));
  assign do_push = push && !full;
  assign do_take = take_i && (cnt_q != '0);

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_take) begin
      rd_d = (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_take) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = slot_q[rd_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("input queue count out of range");

  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && !push) |=> (cnt_q == '0))
    else $error("input queue count moved without a beat");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_q == wr_q))
    else $error("empty input queue with unequal pointers");

endmodule

// ----- design/swms_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
module swms_div #(
  parameter int unsigned DividendW = 39,
  parameter int unsigned DivisorW  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DividendW + 1);

  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  div_q;
  logic [DividendW-1:0] quo_q;
  logic [StepW-1:0]     step_q;
  logic                 busy_q, done_q;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DividendW-1]};
  assign fits  = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_q <= {quo_q[DividendW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/swms_sqrt.sv -----
// Iterative floor square root, two radicand bits per cycle.
module swms_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [swms_pkg::SqW-1:0]  value_i,
  output logic                      done_o,
  output logic [swms_pkg::SampleW-1:0] root_o
);

  localparam int unsigned W = swms_pkg::SqW;

  logic [W-1:0] v_q, root_q, bit_q;
  logic [W-1:0] trial;
  logic         busy_q, done_q;

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= value_i;
      root_q <= '0;
      bit_q  <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q    <= v_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[swms_pkg::SampleW-1:0];

endmodule

// ----- design/swms_back.sv -----
// Back end: sample store, running sums, sequencer and result register.
module swms_back #(
  parameter int unsigned WINDOW_SIZE = swms_pkg::WindowSizeDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  swms_pkg::in_head_t         head_i,
  output logic                       take_o,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [swms_pkg::SampleW-1:0] mean_o,
  output logic [swms_pkg::SampleW-1:0] std_dev_o,
  output logic [swms_pkg::FillW-1:0] fill_count_o,
  output logic                       full_res_o
);

  localparam int unsigned SW   = swms_pkg::SampleW;
  localparam int unsigned QW   = swms_pkg::SqW;
  localparam int unsigned PtrW = $clog2(WINDOW_SIZE);
  localparam int unsigned CntW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned SumW = SW + CntW;
  localparam int unsigned SqSumW = 2 * SW - 1 + CntW;

  swms_pkg::back_state_e state_q, state_d;

  logic signed [SW-1:0] mem [WINDOW_SIZE];
  logic signed [SW-1:0] old_q;
  logic signed [SW-1:0] x_q;
  logic [PtrW-1:0]      ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic signed [SumW-1:0] sum_q;
  logic [SqSumW-1:0]    sq_q;
  logic [QW-1:0]        x2_q, old2_q;
  logic signed [SW-1:0] old_eff;
  logic                 win_full;
  logic                 neg_q;
  logic signed [SW-1:0] mean_q;
  logic [QW-1:0]        meansq_q, msq_q, var_q;
  logic [SW-1:0]        sd_q;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_mean_q;
  logic [SW-1:0]        out_sd_q;
  logic [CntW-1:0]      out_cnt_q;
  logic [CntW+swms_pkg::FillW-1:0] cnt_ext;

  logic                 div_start, div_done;
  logic [SqSumW-1:0]    div_dividend, div_quo;
  logic [SumW-1:0]      sum_abs;
  logic                 sqrt_start, sqrt_done;
  logic [SW-1:0]        sqrt_root;
  logic                 out_free;

  assign win_full = (cnt_q == CntW'(WINDOW_SIZE));
  assign old_eff  = win_full ? old_q : '0;
  assign sum_abs  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign out_free = !out_valid_q || pop;

  always_comb begin
    state_d      = state_q;
    take_o       = 1'b0;
    div_start    = 1'b0;
    div_dividend = SqSumW'(sum_abs);
    sqrt_start   = 1'b0;
    unique case (state_q)
      swms_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          take_o  = 1'b1;
          state_d = (head_i.item.command == swms_pkg::CMD_CLEAR) ? swms_pkg::ST_DONE
                                                                 : swms_pkg::ST_SQUARE;
        end
      end
      swms_pkg::ST_SQUARE:  state_d = swms_pkg::ST_ACCUM;
      swms_pkg::ST_ACCUM:   state_d = swms_pkg::ST_SUM_GO;
      swms_pkg::ST_SUM_GO: begin
        div_start = 1'b1;
        state_d   = swms_pkg::ST_SUM_WAIT;
      end
      swms_pkg::ST_SUM_WAIT: if (div_done) state_d = swms_pkg::ST_SQ_GO;
      swms_pkg::ST_SQ_GO: begin
        div_start    = 1'b1;
        div_dividend = sq_q;
        state_d      = swms_pkg::ST_SQ_WAIT;
      end
      swms_pkg::ST_SQ_WAIT: if (div_done) state_d = swms_pkg::ST_MUL;
      swms_pkg::ST_MUL:     state_d = swms_pkg::ST_VAR;
      swms_pkg::ST_VAR:     state_d = swms_pkg::ST_SQRT_GO;
      swms_pkg::ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = swms_pkg::ST_SQRT_WAIT;
      end
      swms_pkg::ST_SQRT_WAIT: if (sqrt_done) state_d = swms_pkg::ST_DONE;
      swms_pkg::ST_DONE:    if (out_free) state_d = swms_pkg::ST_IDLE;
      default:              state_d = swms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swms_pkg::ST_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == swms_pkg::ST_IDLE && take_o &&
          head_i.item.command == swms_pkg::CMD_CLEAR) begin
        ptr_q <= '0;
        cnt_q <= '0;
        sum_q <= '0;
        sq_q  <= '0;
      end
      if (state_q == swms_pkg::ST_ACCUM) begin
        sum_q <= sum_q + SumW'(x_q) - SumW'(old_eff);
        sq_q  <= sq_q + SqSumW'(x2_q) - SqSumW'(old2_q);
        ptr_q <= (ptr_q == PtrW'(WINDOW_SIZE - 1)) ? '0 : ptr_q + 1'b1;
        if (!win_full) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == swms_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == swms_pkg::ST_IDLE && take_o) begin
      x_q   <= head_i.item.sample;
      old_q <= mem[ptr_q];
      if (head_i.item.command == swms_pkg::CMD_CLEAR) begin
        mean_q <= '0;
        sd_q   <= '0;
      end
    end
    if (state_q == swms_pkg::ST_SQUARE) begin
      mem[ptr_q] <= x_q;
      x2_q       <= QW'(x_q * x_q);
      old2_q     <= QW'(old_eff * old_eff);
    end
    if (state_q == swms_pkg::ST_SUM_GO) begin
      neg_q <= sum_q[SumW-1];
    end
    if (state_q == swms_pkg::ST_SUM_WAIT && div_done) begin
      mean_q <= neg_q ? -SW'(div_quo) : SW'(div_quo);
    end
    if (state_q == swms_pkg::ST_SQ_WAIT && div_done) begin
      meansq_q <= QW'(div_quo);
    end
    if (state_q == swms_pkg::ST_MUL) begin
      msq_q <= QW'(mean_q * mean_q);
    end
    if (state_q == swms_pkg::ST_VAR) begin
      var_q <= (meansq_q > msq_q) ? meansq_q - msq_q : '0;
    end
    if (state_q == swms_pkg::ST_SQRT_WAIT && sqrt_done) begin
      sd_q <= sqrt_root;
    end
    if (state_q == swms_pkg::ST_DONE && out_free) begin
      out_mean_q <= mean_q;
      out_sd_q   <= sd_q;
      out_cnt_q  <= cnt_q;
    end
  end

  swms_div #(
    .DividendW (SqSumW),
    .DivisorW  (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  swms_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (var_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign cnt_ext      = {{swms_pkg::FillW{1'b0}}, out_cnt_q};
  assign empty        = !out_valid_q;
  assign mean_o       = out_mean_q;
  assign std_dev_o    = out_sd_q;
  assign fill_count_o = cnt_ext[swms_pkg::FillW-1:0];
  assign full_res_o   = (out_cnt_q == CntW'(WINDOW_SIZE));

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(WINDOW_SIZE))
    else $error("fill count above window size");

  a_ptr_follows_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_full |-> (CntW'(ptr_q) == cnt_q))
    else $error("write pointer out of step with fill count");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> (state_q == swms_pkg::ST_IDLE && head_i.valid))
    else $error("item taken outside idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(out_mean_q)))
    else $error("waiting result overwritten");

endmodule

// ----- bench/sliding_window_mean_stddev_tb.sv -----
// Self-checking testbench for the sliding window mean and standard deviation block.
module sliding_window_mean_stddev_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Window = swms_pkg::WindowSizeDef;

  typedef struct packed {
    logic signed [15:0] mean;
    logic [15:0]        std_dev;
    logic [7:0]         fill_count;
    logic               full_res;
  } stats_t;

  typedef struct {
    swms_pkg::cmd_e     command;
    logic signed [15:0] sample;
    logic               has_expect;
    stats_t             expect_val;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic command_i = 1'b0;
  logic signed [15:0] sample_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] mean_o;
  logic [15:0] std_dev_o;
  logic [7:0] fill_count_o;
  logic full_res_o;

  sliding_window_mean_stddev uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .command_i(command_i), .sample_i(sample_i), .empty(empty), .pop(pop),
    .mean_o(mean_o), .std_dev_o(std_dev_o), .fill_count_o(fill_count_o),
    .full_res_o(full_res_o)
  );

  always #10 clk_i = ~clk_i;

  logic signed [15:0] window_samples [Window];
  int unsigned        slot_ptr;
  int unsigned        samples_held;
  longint             sum_codes;
  longint             sum_squares;
  stats_t             pending_stats [$];
  row_t               directed_rows [$];
  int                 error_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  function automatic longint isqrt(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v) r += longint'(1) << b;
    end
    return r;
  endfunction

  function automatic stats_t window_stats(swms_pkg::cmd_e cmd, logic signed [15:0] s);
    stats_t  st;
    longint  m;
    longint  v;
    longint  x;
    longint  old;
    if (cmd == swms_pkg::CMD_CLEAR) begin
      foreach (window_samples[i]) window_samples[i] = '0;
      slot_ptr = 0;
      samples_held = 0;
      sum_codes = 0;
      sum_squares = 0;
    end else begin
      x = s;
      old = window_samples[slot_ptr];
      window_samples[slot_ptr] = s;
      slot_ptr = (slot_ptr + 1 >= Window) ? 0 : slot_ptr + 1;
      if (samples_held < Window) samples_held++;
      sum_codes += x - old;
      sum_squares += x * x - old * old;
    end
    m = 0;
    v = 0;
    if (samples_held != 0) begin
      m = sum_codes / longint'(samples_held);
      v = sum_squares / longint'(samples_held) - m * m;
      if (v < 0) v = 0;
      v = isqrt(v);
    end
    st.mean = m[15:0];
    st.std_dev = v[15:0];
    st.fill_count = samples_held[7:0];
    st.full_res = (samples_held == Window);
    return st;
  endfunction

  task automatic send_beat(swms_pkg::cmd_e cmd, logic signed [15:0] s, logic has_exp,
                           stats_t exp_v);
    stats_t st;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    sample_i <= s;
    do @(posedge clk_i); while (full);
    st = window_stats(cmd, s);
    if (has_exp && st != exp_v) begin
      $error("directed row expectation differs: expected %h predicted %h", exp_v, st);
      error_count++;
    end
    pending_stats.push_back(st);
  endtask

  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_stats.size() == 0) begin
        $error("unexpected result beat");
        error_count++;
      end else begin
        want = pending_stats.pop_front();
        if (mean_o !== want.mean) begin
          $error("mean: expected %0d actual %0d", want.mean, mean_o); error_count++;
        end
        if (std_dev_o !== want.std_dev) begin
          $error("std_dev: expected %0d actual %0d", want.std_dev, std_dev_o); error_count++;
        end
        if (fill_count_o !== want.fill_count) begin
          $error("fill_count: expected %0d actual %0d", want.fill_count, fill_count_o);
          error_count++;
        end
        if (full_res_o !== want.full_res) begin
          $error("full_res: expected %0d actual %0d", want.full_res, full_res_o);
          error_count++;
        end
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic stats_t mk(int m, int s, int f, int fr);
    stats_t st;
    st.mean = 16'(m);
    st.std_dev = 16'(s);
    st.fill_count = 8'(f);
    st.full_res = 1'(fr);
    return st;
  endfunction

  function automatic void add_row(swms_pkg::cmd_e c, int s, logic he, stats_t e);
    row_t r;
    r.command = c;
    r.sample = 16'(s);
    r.has_expect = he;
    r.expect_val = e;
    directed_rows.push_back(r);
  endfunction

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    logic signed [15:0] s;
    int mode;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    mode = $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        1, 2: s = $signed(16'($urandom_range(600))) - 16'sd300;
        default: s = (mode == 0) ? 16'($urandom) : $signed(16'($urandom_range(4000))) - 16'sd2000;
      endcase
      send_beat(($urandom_range(199) == 0) ? swms_pkg::CMD_CLEAR : swms_pkg::CMD_PUSH, s,
                1'b0, '0);
    end
  endtask

  initial begin
    #25ms;
    $display("sliding_window_mean_stddev_tb failed");
    $finish;
  end

  initial begin
    stats_t none;
    int guard;
    none = '0;
    foreach (window_samples[i]) window_samples[i] = '0;
    slot_ptr = 0;
    samples_held = 0;
    sum_codes = 0;
    sum_squares = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(swms_pkg::CMD_CLEAR, 16'h1234, 1'b1, mk(0, 0, 0, 0));
    add_row(swms_pkg::CMD_PUSH, 32767, 1'b1, mk(32767, 0, 1, 0));
    add_row(swms_pkg::CMD_PUSH, -32768, 1'b0, none);
    add_row(swms_pkg::CMD_PUSH, -32768, 1'b0, none);
    add_row(swms_pkg::CMD_PUSH, 32767, 1'b0, none);
    add_row(swms_pkg::CMD_CLEAR, 0, 1'b1, mk(0, 0, 0, 0));
    add_row(swms_pkg::CMD_PUSH, -32768, 1'b1, mk(-32768, 0, 1, 0));
    add_row(swms_pkg::CMD_PUSH, 0, 1'b1, mk(-16384, 16384, 2, 0));
    add_row(swms_pkg::CMD_PUSH, -1, 1'b0, none);
    add_row(swms_pkg::CMD_PUSH, 16'h5555, 1'b0, none);
    add_row(swms_pkg::CMD_PUSH, 16'hAAAA, 1'b0, none);
    add_row(swms_pkg::CMD_CLEAR, -1, 1'b1, mk(0, 0, 0, 0));
    add_row(swms_pkg::CMD_PUSH, -3, 1'b1, mk(-3, 0, 1, 0));
    add_row(swms_pkg::CMD_PUSH, 2, 1'b0, none);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].command, directed_rows[i].sample,
                directed_rows[i].has_expect, directed_rows[i].expect_val);
    // Fill the window with extremes so it wraps with the full flag set.
    for (int i = 0; i < 140; i++)
      send_beat(swms_pkg::CMD_PUSH, (i % 2) ? 16'sh7FFF : 16'sh8000, 1'b0, none);
    for (int i = 0; i < 130; i++) send_beat(swms_pkg::CMD_PUSH, 16'sh7FFF, 1'b0, none);

    random_phase(220, 0, 0);
    random_phase(200, 84, 0);
    random_phase(200, 0, 84);
    random_phase(245, 35, 35);
    send_beat(swms_pkg::CMD_CLEAR, 0, 1'b1, mk(0, 0, 0, 0));
    push <= 1'b0;

    recv_stall_pct = 0;
    guard = 0;
    while (pending_stats.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (250) @(posedge clk_i);
    if (error_count == 0 && pending_stats.size() == 0) begin
      $display("sliding_window_mean_stddev_tb passed");
    end else begin
      $display("sliding_window_mean_stddev_tb failed");
    end
    $finish;
  end
endmodule
